>>> src/damped_spring_pair_force_core_defines.svh
// Assertion macros for the damped spring pair force core.
// A check of the form "antecedent implies consequent", in the same cycle
// or in the next one, clocked on clk_i and idle while rst_ni is low.
`ifndef DAMPED_SPRING_PAIR_FORCE_CORE_DEFINES_SVH
`define DAMPED_SPRING_PAIR_FORCE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DSPF_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("dspf: same-cycle check failed");
`define DSPF_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("dspf: next-cycle check failed");
`else
`define DSPF_ASSERT_NOW(lbl, ant, con)
`define DSPF_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

>>> src/dspf_pkg.sv
package dspf_pkg;

  // One particle pair, all signed Q16.16
  typedef struct packed {
    logic signed [31:0] self_pos_x;
    logic signed [31:0] self_pos_y;
    logic signed [31:0] self_pos_z;
    logic signed [31:0] self_vel_x;
    logic signed [31:0] self_vel_y;
    logic signed [31:0] self_vel_z;
    logic signed [31:0] peer_pos_x;
    logic signed [31:0] peer_pos_y;
    logic signed [31:0] peer_pos_z;
    logic signed [31:0] peer_vel_x;
    logic signed [31:0] peer_vel_y;
    logic signed [31:0] peer_vel_z;
  } dspf_in_t;

  // Summed force, signed Q16.16, plus saturation flag
  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               clipped;
  } dspf_out_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_STIFFNESS = 2'd0,
    CFG_REST_LEN  = 2'd1,
    CFG_DAMP_GAIN = 2'd2
  } dspf_cfg_e;

  localparam logic [31:0] STIFFNESS_RST = 32'd65536;
  localparam logic [30:0] REST_LEN_RST  = 31'd65536;
  localparam logic [15:0] DAMP_GAIN_RST = 16'd6554;

  // Unit vector pipeline: squares, sum, one root bit per stage,
  // one quotient bit per stage
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;
  localparam int UNIT_LAT    = 2 + SQRT_STAGES + DIV_STAGES;
  localparam int SQ_REM_W    = 35;

endpackage

>>> src/dspf_unit_vec.sv
// Length and Q2.30 unit vector of a signed Q16.16 3-vector, fully pipelined
module dspf_unit_vec import dspf_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] vec_i [3],
  output logic        [31:0] len_o,
  output logic signed [31:0] unit_o [3]
);

  // Stage 1: magnitudes and squares
  logic [31:0] in_mag [3];
  logic [31:0] s1_mag_q [3];
  logic [2:0]  s1_neg_q;
  logic [63:0] s1_sq_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = vec_i[i][31] ? (~$unsigned(vec_i[i]) + 32'd1) : $unsigned(vec_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_q[i] <= in_mag[i];
        s1_neg_q[i] <= vec_i[i][31];
        s1_sq_q[i]  <= in_mag[i] * in_mag[i];
      end
    end
  end

  // Stage 2: sum of squares (at most 3 * 2^62, fits 64 bits)
  logic [31:0] s2_mag_q [3];
  logic [2:0]  s2_neg_q;
  logic [63:0] s2_ss_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      s2_ss_q  <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    end
  end

  // Square root, one result bit per stage
  logic [SQ_REM_W-1:0] sq_rem_q  [SQRT_STAGES];
  logic [31:0]         sq_root_q [SQRT_STAGES];
  logic [63:0]         sq_rad_q  [SQRT_STAGES];
  logic [31:0]         sq_mag_q  [SQRT_STAGES][3];
  logic [2:0]          sq_neg_q  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam int HI = 63 - 2 * k;
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic [31:0]         root_in;
    logic [63:0]         rad_in;
    logic [31:0]         mag_in [3];
    logic [2:0]          neg_in;
    logic                take;

    if (k == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = s2_ss_q;
      assign mag_in  = s2_mag_q;
      assign neg_in  = s2_neg_q;
    end else begin : g_body
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign mag_in  = sq_mag_q[k-1];
      assign neg_in  = sq_neg_q[k-1];
    end

    assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[HI -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        sq_root_q[k] <= {root_in[30:0], take};
        sq_rad_q[k]  <= rad_in;
        sq_mag_q[k]  <= mag_in;
        sq_neg_q[k]  <= neg_in;
      end
    end
  end

  // Restoring division (mag << 30) / len, one quotient bit per stage and lane
  logic [31:0] dv_rem_q [DIV_STAGES][3];
  logic [30:0] dv_quo_q [DIV_STAGES][3];
  logic [31:0] dv_len_q [DIV_STAGES];
  logic [2:0]  dv_neg_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [31:0] rem_in [3];
    logic [30:0] quo_in [3];
    logic [2:0]  bit_in;
    logic [31:0] len_in;
    logic [2:0]  neg_in;
    logic [32:0] part [3];
    logic [32:0] diff [3];
    logic [2:0]  take;

    if (j == 0) begin : g_head
      assign len_in = sq_root_q[SQRT_STAGES-1];
      assign neg_in = sq_neg_q[SQRT_STAGES-1];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {1'b0, sq_mag_q[SQRT_STAGES-1][i][31:1]};
          quo_in[i] = '0;
          bit_in[i] = sq_mag_q[SQRT_STAGES-1][i][0];
        end
      end
    end else begin : g_body
      assign len_in = dv_len_q[j-1];
      assign neg_in = dv_neg_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign quo_in = dv_quo_q[j-1];
      assign bit_in = '0;
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i] = {rem_in[i], bit_in[i]};
        diff[i] = part[i] - {1'b0, len_in};
        take[i] = (part[i] >= {1'b0, len_in});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j][i] <= take[i] ? diff[i][31:0] : part[i][31:0];
          dv_quo_q[j][i] <= {quo_in[i][29:0], take[i]};
        end
        dv_len_q[j] <= len_in;
        dv_neg_q[j] <= neg_in;
      end
    end
  end

  // Signed result; a zero-length vector gives a zero unit vector
  logic [31:0] quo_ext [3];

  assign len_o = dv_len_q[DIV_STAGES-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_ext[i] = {1'b0, dv_quo_q[DIV_STAGES-1][i]};
      if (len_o == '0) begin
        unit_o[i] = '0;
      end else if (dv_neg_q[DIV_STAGES-1][i]) begin
        unit_o[i] = $signed(~quo_ext[i] + 32'd1);
      end else begin
        unit_o[i] = $signed(quo_ext[i]);
      end
    end
  end

endmodule

>>> src/damped_spring_pair_force_core.sv
// Damped spring force on one particle of a pair, one pair per clock.
// Path: the difference register loads at the accepting edge, then a 65-stage unit vector
// pipeline and 8 force stages incl. output lead to out_valid_o.
// Throughput: one transaction per cycle; a stall at the output freezes the whole pipeline.
// Reset: valid bits clear, configuration returns to k = 1.0, L = 1.0, gain = 6554.
`include "damped_spring_pair_force_core_defines.svh"

module damped_spring_pair_force_core import dspf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dspf_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dspf_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  function automatic logic signed [31:0] sat33(input logic signed [32:0] a);
    if (a[32] != a[31]) begin
      return a[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return $signed(a[31:0]);
  endfunction

  function automatic logic [30:0] mag31(input logic signed [31:0] a);
    logic [31:0] n;
    n = ~$unsigned(a) + 32'd1;
    return a[31] ? n[30:0] : a[30:0];
  endfunction

  // Configuration registers
  logic [31:0] k_q;
  logic [30:0] rest_q;
  logic [15:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= STIFFNESS_RST;
      rest_q <= REST_LEN_RST;
      gain_q <= DAMP_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (dspf_cfg_e'(cfg_index_i))
        CFG_STIFFNESS: k_q    <= cfg_data_i;
        CFG_REST_LEN:  rest_q <= cfg_data_i[30:0];
        CFG_DAMP_GAIN: gain_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or being taken
  logic pipe_en;
  logic out_vld_q;

  assign pipe_en    = !out_vld_q || out_ready_i;
  assign in_ready_o = pipe_en;

  // Stage 0: position and velocity differences, saturated
  logic signed [31:0] self_pos [3], peer_pos [3], self_vel [3], peer_vel [3];
  logic signed [32:0] d_raw [3], v_raw [3];
  logic signed [31:0] d_sat [3], v_sat [3];
  logic               diff_clip;

  always_comb begin
    self_pos = '{in_data_i.self_pos_x, in_data_i.self_pos_y, in_data_i.self_pos_z};
    peer_pos = '{in_data_i.peer_pos_x, in_data_i.peer_pos_y, in_data_i.peer_pos_z};
    self_vel = '{in_data_i.self_vel_x, in_data_i.self_vel_y, in_data_i.self_vel_z};
    peer_vel = '{in_data_i.peer_vel_x, in_data_i.peer_vel_y, in_data_i.peer_vel_z};
    diff_clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d_raw[i] = {self_pos[i][31], self_pos[i]} - {peer_pos[i][31], peer_pos[i]};
      v_raw[i] = {self_vel[i][31], self_vel[i]} - {peer_vel[i][31], peer_vel[i]};
      d_sat[i] = sat33(d_raw[i]);
      v_sat[i] = sat33(v_raw[i]);
      diff_clip = diff_clip | (d_raw[i][32] != d_raw[i][31]) | (v_raw[i][32] != v_raw[i][31]);
    end
  end

  // Side line alongside the unit vector pipelines
  logic               line_vld_q  [UNIT_LAT+1];
  logic               line_clip_q [UNIT_LAT+1];
  logic signed [31:0] line_v_q    [UNIT_LAT+1][3];
  logic signed [31:0] t0_d_q      [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= UNIT_LAT; s++) line_vld_q[s] <= 1'b0;
    end else if (pipe_en) begin
      line_vld_q[0] <= in_valid_i;
      for (int s = 1; s <= UNIT_LAT; s++) line_vld_q[s] <= line_vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t0_d_q         <= d_sat;
      line_v_q[0]    <= v_sat;
      line_clip_q[0] <= diff_clip;
      for (int s = 1; s <= UNIT_LAT; s++) begin
        line_v_q[s]    <= line_v_q[s-1];
        line_clip_q[s] <= line_clip_q[s-1];
      end
    end
  end

  // Unit vectors of d and v
  logic        [31:0] d_len;
  logic signed [31:0] d_u [3];
  logic signed [31:0] w_u [3];

  dspf_unit_vec u_unit_d (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .vec_i  (t0_d_q),
    .len_o  (d_len),
    .unit_o (d_u)
  );

  dspf_unit_vec u_unit_v (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .vec_i  (line_v_q[0]),
    .len_o  (),
    .unit_o (w_u)
  );

  // Force stage valid and flag chain, P1 .. P7
  localparam int FS = 7;
  logic fs_vld_q  [FS];
  logic fs_clip_q [FS];
  logic fs_clip_d [FS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < FS; s++) fs_vld_q[s] <= 1'b0;
    end else if (pipe_en) begin
      fs_vld_q[0] <= line_vld_q[UNIT_LAT];
      for (int s = 1; s < FS; s++) fs_vld_q[s] <= fs_vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) fs_clip_q <= fs_clip_d;
  end

  // P1: stretch and stiffness product
  logic signed [32:0] stretch;
  logic        [32:0] stretch_abs;
  logic        [63:0] p1_mprod_q;
  logic               p1_sneg_q;
  logic signed [31:0] p1_u_q [3], p1_w_q [3], p1_v_q [3];

  assign stretch     = $signed({1'b0, d_len}) - $signed({2'b00, rest_q});
  assign stretch_abs = stretch[32] ? $unsigned(-stretch) : $unsigned(stretch);
  assign fs_clip_d[0] = line_clip_q[UNIT_LAT];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_mprod_q <= k_q * stretch_abs[31:0];
      p1_sneg_q  <= stretch[32];
      p1_u_q     <= d_u;
      p1_w_q     <= w_u;
      p1_v_q     <= line_v_q[UNIT_LAT];
    end
  end

  // P2: spring magnitude m, saturated to 2^31-1
  logic [47:0]        m_sh;
  logic               m_ovf;
  logic [30:0]        p2_mmag_q;
  logic               p2_mneg_q;
  logic signed [31:0] p2_u_q [3], p2_w_q [3], p2_v_q [3];

  assign m_sh  = p1_mprod_q[63:16];
  assign m_ovf = |m_sh[47:31];
  assign fs_clip_d[1] = fs_clip_q[0] | m_ovf;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p2_mmag_q <= m_ovf ? 31'h7FFF_FFFF : m_sh[30:0];
      p2_mneg_q <= p1_sneg_q;
      p2_u_q    <= p1_u_q;
      p2_w_q    <= p1_w_q;
      p2_v_q    <= p1_v_q;
    end
  end

  // P3: m * |u_i|; S_i is negative when m and u_i share a sign
  logic [61:0]        p3_sprod_q [3];
  logic [2:0]         p3_sneg_q;
  logic signed [31:0] p3_w_q [3], p3_v_q [3];

  assign fs_clip_d[2] = fs_clip_q[1];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        p3_sprod_q[i] <= p2_mmag_q * mag31(p2_u_q[i]);
        p3_sneg_q[i]  <= (p2_mneg_q == p2_u_q[i][31]);
      end
      p3_w_q <= p2_w_q;
      p3_v_q <= p2_v_q;
    end
  end

  // P4: spring force S and the terms of v . S
  logic        [31:0] s_mag [3];
  logic signed [31:0] s_val [3];
  logic signed [31:0] p4_s_q [3], p4_w_q [3];
  logic signed [63:0] p4_vs_q [3];

  assign fs_clip_d[3] = fs_clip_q[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_mag[i] = p3_sprod_q[i][61:30];
      s_val[i] = p3_sneg_q[i] ? $signed(~s_mag[i] + 32'd1) : $signed(s_mag[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) p4_vs_q[i] <= p3_v_q[i] * s_val[i];
      p4_s_q <= s_val;
      p4_w_q <= p3_w_q;
    end
  end

  // P5: dot product, scaled by the damping gain
  logic signed [65:0] dot;
  logic        [65:0] dot_abs;
  logic        [62:0] p5_gprod_q;
  logic               p5_dneg_q;
  logic signed [31:0] p5_s_q [3], p5_w_q [3];

  assign dot = {{2{p4_vs_q[0][63]}}, p4_vs_q[0]} + {{2{p4_vs_q[1][63]}}, p4_vs_q[1]}
             + {{2{p4_vs_q[2][63]}}, p4_vs_q[2]};
  assign dot_abs = dot[65] ? $unsigned(-dot) : $unsigned(dot);
  assign fs_clip_d[4] = fs_clip_q[3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p5_gprod_q <= dot_abs[62:16] * gain_q;
      p5_dneg_q  <= dot[65];
      p5_s_q     <= p4_s_q;
      p5_w_q     <= p4_w_q;
    end
  end

  // P6: damping magnitude, saturated to 2^31-1
  logic [46:0]        dm_sh;
  logic               dm_ovf;
  logic [30:0]        p6_dmag_q;
  logic               p6_dneg_q;
  logic signed [31:0] p6_s_q [3], p6_w_q [3];

  assign dm_sh  = p5_gprod_q[62:16];
  assign dm_ovf = |dm_sh[46:31];
  assign fs_clip_d[5] = fs_clip_q[4] | dm_ovf;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p6_dmag_q <= dm_ovf ? 31'h7FFF_FFFF : dm_sh[30:0];
      p6_dneg_q <= p5_dneg_q;
      p6_s_q    <= p5_s_q;
      p6_w_q    <= p5_w_q;
    end
  end

  // P7: dm * |w_i|; the product is negative when dm and w_i differ in sign
  logic [61:0]        p7_dprod_q [3];
  logic [2:0]         p7_dneg_q;
  logic signed [31:0] p7_s_q [3];

  assign fs_clip_d[6] = fs_clip_q[5];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        p7_dprod_q[i] <= p6_dmag_q * mag31(p6_w_q[i]);
        p7_dneg_q[i]  <= (p6_dneg_q != p6_w_q[i][31]);
      end
      p7_s_q <= p6_s_q;
    end
  end

  // Output register: S - D, saturated
  logic        [31:0] d_mag [3];
  logic signed [31:0] d_val [3];
  logic signed [32:0] f_raw [3];
  logic signed [31:0] f_sat [3];
  logic               f_clip;
  dspf_out_t          out_d, out_q;

  always_comb begin
    f_clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d_mag[i] = p7_dprod_q[i][61:30];
      d_val[i] = p7_dneg_q[i] ? $signed(~d_mag[i] + 32'd1) : $signed(d_mag[i]);
      f_raw[i] = {p7_s_q[i][31], p7_s_q[i]} - {d_val[i][31], d_val[i]};
      f_sat[i] = sat33(f_raw[i]);
      f_clip   = f_clip | (f_raw[i][32] != f_raw[i][31]);
    end
    out_d.force_x = f_sat[0];
    out_d.force_y = f_sat[1];
    out_d.force_z = f_sat[2];
    out_d.clipped = fs_clip_q[FS-1] | f_clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= fs_vld_q[FS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  `DSPF_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, line_vld_q[0])
  `DSPF_ASSERT_NEXT(a_stall_freezes, !pipe_en, $stable(line_vld_q[UNIT_LAT]) && $stable(fs_vld_q[FS-1]))
  `DSPF_ASSERT_NOW(a_zero_len_unit, line_vld_q[UNIT_LAT] && d_len == 32'd0, d_u[0] == 32'sd0 && d_u[1] == 32'sd0 && d_u[2] == 32'sd0)

endmodule

>>> sim/testbench.sv
module testbench;
  import dspf_pkg::*;

  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;
  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int DRAIN_CYCLES    = 100;
  localparam int STALL_LIMIT     = 20000;
  localparam int RAND_ITEMS      = 1100;

  typedef longint vec3_t[3];

  typedef struct {
    dspf_in_t  pair;
    bit        typed;
    dspf_out_t force_lit;
  } pair_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  dspf_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  dspf_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_STIFFNESS;
  logic [31:0] cfg_data_i = '0;

  // row tag travelling with the input transaction
  logic        cur_typed = 1'b0;
  dspf_out_t   cur_lit = '0;

  // local copy of the registers
  logic [31:0] k_reg = STIFFNESS_RST;
  logic [30:0] len_reg = REST_LEN_RST;
  logic [15:0] gain_reg = DAMP_GAIN_RST;

  dspf_out_t   force_q[$];
  int          mismatches = 0;
  int          send_idle = 38;
  int          recv_idle = 68;
  int          stall_cnt = 0;
  bit          sat_hit;
  pair_row_t   rows[$];

  damped_spring_pair_force_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- force predictor ----------------
  function automatic longint sat_to(longint v, longint lo, longint hi);
    if (v > hi) begin
      sat_hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat_hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // sign-magnitude product, shifted, truncated toward zero
  function automatic longint mul_shift(longint a, longint b, int sh);
    longint unsigned p;
    p = (mag(a) * mag(b)) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q2.30 unit vector; returns the length
  function automatic longint unsigned normalise(input vec3_t v, output vec3_t u);
    longint unsigned ss, len, q;
    ss = 0;
    for (int i = 0; i < 3; i++) ss += mag(v[i]) * mag(v[i]);
    len = int_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      q = (len != 0) ? (mag(v[i]) << 30) / len : 0;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return len;
  endfunction

  function automatic dspf_out_t spring_force(dspf_in_t p);
    vec3_t d, v, u, w, s;
    longint sp[3], sv[3], pp[3], pv[3];
    longint unsigned len, dmag;
    longint stretch, m, dot, dm, f;
    dspf_out_t r;
    sat_hit = 1'b0;
    sp = '{p.self_pos_x, p.self_pos_y, p.self_pos_z};
    sv = '{p.self_vel_x, p.self_vel_y, p.self_vel_z};
    pp = '{p.peer_pos_x, p.peer_pos_y, p.peer_pos_z};
    pv = '{p.peer_vel_x, p.peer_vel_y, p.peer_vel_z};
    for (int i = 0; i < 3; i++) begin
      d[i] = sat_to(sp[i] - pp[i], SAT_LO, SAT_HI);
      v[i] = sat_to(sv[i] - pv[i], SAT_LO, SAT_HI);
    end
    len = normalise(d, u);
    stretch = longint'(len) - longint'(len_reg);
    m = sat_to(mul_shift(longint'(k_reg), stretch, 16), -SAT_HI, SAT_HI);
    for (int i = 0; i < 3; i++) s[i] = -mul_shift(m, u[i], 30);
    dot = 0;
    for (int i = 0; i < 3; i++) dot += v[i] * s[i];
    dmag = ((mag(dot) >> 16) * longint'(gain_reg)) >> 16;
    dm = sat_to(longint'(dmag), 0, SAT_HI);
    if (dot < 0) dm = -dm;
    void'(normalise(v, w));
    for (int i = 0; i < 3; i++) begin
      f = sat_to(s[i] - mul_shift(dm, w[i], 30), SAT_LO, SAT_HI);
      case (i)
        0: r.force_x = f[31:0];
        1: r.force_y = f[31:0];
        default: r.force_z = f[31:0];
      endcase
    end
    r.clipped = sat_hit;
    return r;
  endfunction

  // ---------------- monitors ----------------
  always @(posedge clk_i) begin
    dspf_out_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_STIFFNESS: k_reg <= cfg_data_i;
          CFG_REST_LEN:  len_reg <= cfg_data_i[30:0];
          CFG_DAMP_GAIN: gain_reg <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        force_q.push_back(cur_typed ? cur_lit : spring_force(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (force_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          want = force_q.pop_front();
          if (out_data_o.force_x !== want.force_x || out_data_o.force_y !== want.force_y ||
              out_data_o.force_z !== want.force_z || out_data_o.clipped !== want.clipped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("force mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_idle);

  // ---------------- stimulus ----------------
  function automatic logic [31:0] near_zero();
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  function automatic dspf_in_t rand_pair();
    dspf_in_t p;
    int shape;
    shape = $urandom_range(9);
    for (int i = 0; i < 12; i++)
      p[i*32 +: 32] = (shape < 3) ? $urandom() : near_zero();
    if (shape == 7) {p.peer_pos_x, p.peer_pos_y, p.peer_pos_z} =
                    {p.self_pos_x, p.self_pos_y, p.self_pos_z};
    if (shape == 8) {p.peer_vel_x, p.peer_vel_y, p.peer_vel_z} =
                    {p.self_vel_x, p.self_vel_y, p.self_vel_z};
    return p;
  endfunction

  task automatic send_pair(dspf_in_t p, bit typed, dspf_out_t lit);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    cur_typed  <= typed;
    cur_lit    <= lit;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  function automatic void add_row(dspf_in_t p, bit typed);
    pair_row_t r;
    r.pair = p;
    r.typed = typed;
    r.force_lit = '0;
    rows.push_back(r);
  endfunction

  initial begin
    dspf_in_t p;
    logic [31:0] settings[4][3];
    int sent;

    // directed rows: zero force where read off directly
    add_row('0, 1'b1);
    add_row({12{32'h7FFF_FFFF}}, 1'b1);
    add_row({12{32'h8000_0000}}, 1'b1);
    // coincident positions; velocity difference may still saturate
    p = rand_pair();
    {p.peer_pos_x, p.peer_pos_y, p.peer_pos_z} = {p.self_pos_x, p.self_pos_y, p.self_pos_z};
    add_row(p, 1'b0);
    // separation saturates on each axis in turn
    for (int a = 0; a < 3; a++) begin
      p = '0;
      p[(11 - a)*32 +: 32] = 32'h7FFF_FFFF;
      p[(5 - a)*32 +: 32]  = 32'h8000_0000;
      add_row(p, 1'b0);
      p[(11 - a)*32 +: 32] = 32'h8000_0000;
      p[(5 - a)*32 +: 32]  = 32'h7FFF_FFFF;
      add_row(p, 1'b0);
    end
    // extreme opposite velocities with a stretched spring
    p = '0;
    p.self_pos_x = 32'h0003_0000;
    p.self_vel_x = 32'h7FFF_FFFF;  p.peer_vel_x = 32'h8000_0000;
    p.self_vel_y = 32'h8000_0000;  p.peer_vel_y = 32'h7FFF_FFFF;
    add_row(p, 1'b0);
    // equal velocities, compressed spring
    p = rand_pair();
    p.self_pos_x = 32'h0000_4000; p.peer_pos_x = 32'h0;
    {p.peer_vel_x, p.peer_vel_y, p.peer_vel_z} = {p.self_vel_x, p.self_vel_y, p.self_vel_z};
    add_row(p, 1'b0);
    add_row({12{32'hAAAA_AAAA}}, 1'b0);
    add_row({6{32'h5555_5555, 32'hAAAA_AAAA}}, 1'b0);
    add_row({{6{32'h0001_0000}}, {6{32'hFFFF_0000}}}, 1'b0);
    for (int i = 0; i < 4; i++) add_row(rand_pair(), 1'b0);

    // register settings, extremes included
    settings[0] = '{32'h0, 32'h0, 32'h0};
    settings[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    settings[2] = '{$urandom(), $urandom_range(0, 32'h0010_0000), $urandom()};
    settings[3] = '{32'h0002_8000, 32'h0000_8000, 32'h0000_8000};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].force_lit);

    sent = 0;
    for (int s = 0; s < 4; s++) begin
      drain();
      write_reg(CFG_STIFFNESS, settings[s][0]);
      write_reg(CFG_REST_LEN, settings[s][1]);
      write_reg(CFG_DAMP_GAIN, settings[s][2]);
      write_reg(CFG_NONE, $urandom());
      cfg_valid_i <= 1'b0;
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        if (sent == RAND_ITEMS / 3) begin
          send_idle = 68;
          recv_idle = 38;
        end else if (sent == 2 * RAND_ITEMS / 3) begin
          send_idle = 0;
          recv_idle = 0;
        end
        send_pair(rand_pair(), 1'b0, '0);
        sent++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/dspf_pkg.sv
src/dspf_unit_vec.sv
src/damped_spring_pair_force_core.sv
sim/testbench.sv
